>>> rtl/jsud_pkg.sv
// Package: shared types, codes and decode helpers for the JSON string unescape decoder.
package jsud_pkg;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Input item kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    // Characters with a role in the string syntax
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    // UTF-8 encoding limits and lead bytes
    localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
    localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
    localparam logic [7:0]  LEAD_TWO     = 8'hC0;
    localparam logic [7:0]  LEAD_THREE   = 8'hE0;
    localparam logic [7:0]  CONT_BYTE    = 8'h80;

    // Front state
    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STR,
        MODE_ESC,
        MODE_HEX
    } t_mode;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       last;
    } t_out_item;

    // One queued command: 1 to 3 results from a single item
    typedef struct packed {
        logic [1:0] cnt;
        logic [1:0] status;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [3:0] nib;
    } t_hex;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_esc;

    // Hex digit decode
    function automatic t_hex hex_value(input logic [7:0] c);
        t_hex r;
        r.ok  = 1'b0;
        r.nib = 4'h0;
        case (c) inside
            [8'h30:8'h39]: begin
                r.ok  = 1'b1;
                r.nib = c[3:0];
            end
            [8'h41:8'h46], [8'h61:8'h66]: begin
                r.ok  = 1'b1;
                r.nib = c[3:0] + 4'd9;
            end
            default: begin
                r.ok  = 1'b0;
                r.nib = 4'h0;
            end
        endcase
        return r;
    endfunction

    // Single-byte escape letters
    function automatic t_esc esc_byte(input logic [7:0] c);
        t_esc r;
        r.ok    = 1'b1;
        r.value = c;
        case (c)
            CH_QUOTE:  r.value = CH_QUOTE;
            CH_BSLASH: r.value = CH_BSLASH;
            8'h2F:     r.value = 8'h2F;
            8'h6E:     r.value = 8'h0A;
            8'h72:     r.value = 8'h0D;
            8'h74:     r.value = 8'h09;
            8'h62:     r.value = 8'h08;
            8'h66:     r.value = 8'h0C;
            default: begin
                r.ok    = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/jsud_front.sv
// Front: accepts items, tracks string/escape/hex mode and queues result commands.
module jsud_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  jsud_pkg::t_in_item i_in_item,
    input  logic             i_full,
    output logic             o_push,
    output jsud_pkg::t_cmd   o_cmd
);
    import jsud_pkg::*;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_cp, n_cp;

    logic        accept;
    t_hex        hex;
    t_esc        esc;
    logic [15:0] cp_full;

    assign o_in_ready = ~i_full;
    assign accept     = i_in_valid & ~i_full;
    assign hex        = hex_value(i_in_item.data_byte);
    assign esc        = esc_byte(i_in_item.data_byte);
    assign cp_full    = {r_cp[11:0], hex.nib};

    // Next state
    always_comb begin
        n_mode      = r_mode;
        n_hex_count = r_hex_count;
        n_cp        = r_cp;
        if (accept) begin
            if (i_in_item.kind == KIND_START) begin
                n_mode      = MODE_STR;
                n_hex_count = 2'd0;
                n_cp        = 16'h0000;
            end else if (i_in_item.kind == KIND_NOP || r_mode == MODE_IDLE) begin
                n_mode = r_mode;
            end else if (i_in_item.kind == KIND_END) begin
                n_mode = MODE_IDLE;
            end else begin
                case (r_mode)
                    MODE_STR: begin
                        if (i_in_item.data_byte == CH_QUOTE) begin
                            n_mode = MODE_IDLE;
                        end else if (i_in_item.data_byte == CH_BSLASH) begin
                            n_mode = MODE_ESC;
                        end
                    end
                    MODE_ESC: begin
                        if (i_in_item.data_byte == CH_U) begin
                            n_mode      = MODE_HEX;
                            n_hex_count = 2'd0;
                            n_cp        = 16'h0000;
                        end else if (!esc.ok) begin
                            n_mode = MODE_IDLE;
                        end else begin
                            n_mode = MODE_STR;
                        end
                    end
                    MODE_HEX: begin
                        if (!hex.ok) begin
                            n_mode = MODE_IDLE;
                        end else if (r_hex_count == 2'd3) begin
                            n_mode      = MODE_STR;
                            n_hex_count = 2'd0;
                            n_cp        = 16'h0000;
                        end else begin
                            n_cp        = cp_full;
                            n_hex_count = r_hex_count + 2'd1;
                        end
                    end
                    default: n_mode = r_mode;
                endcase
            end
        end
    end

    // Result command for the queue
    always_comb begin
        o_push        = 1'b0;
        o_cmd.cnt     = 2'd1;
        o_cmd.status  = ST_BYTE;
        o_cmd.b0      = 8'h00;
        o_cmd.b1      = 8'h00;
        o_cmd.b2      = 8'h00;
        if (accept && i_in_item.kind != KIND_START && i_in_item.kind != KIND_NOP
                && r_mode != MODE_IDLE) begin
            if (i_in_item.kind == KIND_END) begin
                o_push       = 1'b1;
                o_cmd.status = ST_ERROR;
            end else begin
                case (r_mode)
                    MODE_STR: begin
                        if (i_in_item.data_byte == CH_QUOTE) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_DONE;
                        end else if (i_in_item.data_byte != CH_BSLASH) begin
                            o_push   = 1'b1;
                            o_cmd.b0 = i_in_item.data_byte;
                        end
                    end
                    MODE_ESC: begin
                        if (i_in_item.data_byte != CH_U) begin
                            o_push = 1'b1;
                            if (esc.ok) begin
                                o_cmd.b0 = esc.value;
                            end else begin
                                o_cmd.status = ST_ERROR;
                            end
                        end
                    end
                    MODE_HEX: begin
                        if (!hex.ok) begin
                            o_push       = 1'b1;
                            o_cmd.status = ST_ERROR;
                        end else if (r_hex_count == 2'd3) begin
                            o_push = 1'b1;
                            // UTF-8 encode the finished code point
                            if (cp_full < CP_ONE_LIMIT) begin
                                o_cmd.cnt = 2'd1;
                                o_cmd.b0  = cp_full[7:0];
                            end else if (cp_full < CP_TWO_LIMIT) begin
                                o_cmd.cnt = 2'd2;
                                o_cmd.b0  = LEAD_TWO | {3'b000, cp_full[10:6]};
                                o_cmd.b1  = CONT_BYTE | {2'b00, cp_full[5:0]};
                            end else begin
                                o_cmd.cnt = 2'd3;
                                o_cmd.b0  = LEAD_THREE | {4'b0000, cp_full[15:12]};
                                o_cmd.b1  = CONT_BYTE | {2'b00, cp_full[11:6]};
                                o_cmd.b2  = CONT_BYTE | {2'b00, cp_full[5:0]};
                            end
                        end
                    end
                    default: o_push = 1'b0;
                endcase
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_hex_count <= 2'd0;
            r_cp        <= 16'h0000;
        end else begin
            r_mode      <= n_mode;
            r_hex_count <= n_hex_count;
            r_cp        <= n_cp;
        end
    end

endmodule

>>> rtl/jsud_queue.sv
// Queue: short command FIFO between front and back.
module jsud_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsud_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output jsud_pkg::t_cmd o_head,
    input  logic           i_pop
);
    import jsud_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/jsud_back.sv
// Back: expands queued commands into result items through an output register.
module jsud_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  jsud_pkg::t_cmd      i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jsud_pkg::t_out_item o_out_item
);
    import jsud_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = i_q_valid & (~r_out_valid | i_out_ready);
    assign is_last = (r_idx == i_head.cnt - 2'd1);
    assign o_pop   = load & is_last;

    // Byte of the current command
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.b0;
            2'd1:    sel_byte = i_head.b1;
            default: sel_byte = i_head.b2;
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte <= sel_byte;
            r_out_item.status   <= i_head.status;
            r_out_item.last     <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/json_string_unescape_decoder_unit.sv
// Top level: JSON string unescape decoder with \u to UTF-8 expansion.
//
//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_in_item  (kind, data_byte)
//  output    out        o_out_valid / i_out_ready o_out_item (out_byte, status, last)
//
// Accepts one item per cycle unless the queue is full; results leave one per cycle while
// i_out_ready is high, via a queue entry and the output register. A completed \u escape
// gives up to three results and holds the output until all have left; the 4-entry
// command queue absorbs the difference. Input stalls only when the queue is full. Reset
// is synchronous and clears mode, queue and output valid; no clearing pass is needed.
module json_string_unescape_decoder_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  jsud_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output jsud_pkg::t_out_item o_out_item
);
    import jsud_pkg::*;

    logic q_full, q_valid, q_push, q_pop;
    t_cmd push_cmd, head_cmd;

    jsud_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    jsud_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd),
        .i_pop   (q_pop)
    );

    jsud_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/jsud_checker.sv
// Checker: port-level assertions for the decoder, bound to the top level.
module jsud_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input jsud_pkg::t_out_item o_out_item
);
    import jsud_pkg::*;

    // Done and error results carry a zero byte and end their item
    a_marker_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status != ST_BYTE)
            |-> (o_out_item.out_byte == 8'h00 && o_out_item.last))
        else $error("done/error result with data or without last");

    // Only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status == ST_BYTE || o_out_item.status == ST_DONE
                         || o_out_item.status == ST_ERROR))
        else $error("undefined status code");

    // Reset empties the output and the queue
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("output or queue not cleared by reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind json_string_unescape_decoder_unit jsud_checker u_jsud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

>>> verif/jsud_checker.sv
// Checker for the JSON string unescape decoder: predicts results and compares them.
`timescale 1ns / 1ps

module jsud_scoreboard (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  jsud_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  jsud_pkg::t_out_item i_out_item,
    output int                  o_fail_cnt,
    output int                  o_pending_cnt,
    output int                  o_checked_cnt
);
    import jsud_pkg::*;

    // Escape letters that map to a single byte
    localparam logic [7:0] ESC_SLASH = "/";
    localparam logic [7:0] ESC_N     = "n";
    localparam logic [7:0] ESC_R     = "r";
    localparam logic [7:0] ESC_T     = "t";
    localparam logic [7:0] ESC_B     = "b";
    localparam logic [7:0] ESC_F     = "f";

    // Predictor state
    t_mode       scan_mode   = MODE_IDLE;
    logic [1:0]  hex_digits  = 2'd0;
    logic [15:0] code_accum  = 16'd0;

    t_out_item   decoded_results [$];
    int          mismatch_cnt = 0;
    int          checked_cnt  = 0;

    function automatic t_out_item make_result(input logic [7:0] value, input logic [1:0] st);
        t_out_item r;
        r.out_byte = value;
        r.status   = st;
        r.last     = 1'b0;
        return r;
    endfunction

    // Work out the results of one accepted item and queue them
    task automatic decode_item(input t_in_item item);
        t_out_item   res [$];
        logic [7:0]  c;
        logic [7:0]  esc_value;
        logic        esc_ok;
        logic [3:0]  nib;
        logic        nib_ok;
        logic [15:0] cp;
        c = item.data_byte;
        if (item.kind == KIND_START) begin
            scan_mode  = MODE_STR;
            hex_digits = 2'd0;
            code_accum = 16'd0;
        end else if (item.kind != KIND_NOP && scan_mode != MODE_IDLE) begin
            if (item.kind == KIND_END) begin
                res       = {res, make_result(8'h00, ST_ERROR)};
                scan_mode = MODE_IDLE;
            end else begin
                case (scan_mode)
                    MODE_STR: begin
                        if (c == CH_QUOTE) begin
                            res       = {res, make_result(8'h00, ST_DONE)};
                            scan_mode = MODE_IDLE;
                        end else if (c == CH_BSLASH) begin
                            scan_mode = MODE_ESC;
                        end else begin
                            res = {res, make_result(c, ST_BYTE)};
                        end
                    end
                    MODE_ESC: begin
                        if (c == CH_U) begin
                            scan_mode  = MODE_HEX;
                            hex_digits = 2'd0;
                            code_accum = 16'd0;
                        end else begin
                            esc_ok = 1'b1;
                            case (c)
                                CH_QUOTE:  esc_value = CH_QUOTE;
                                CH_BSLASH: esc_value = CH_BSLASH;
                                ESC_SLASH: esc_value = ESC_SLASH;
                                ESC_N:     esc_value = 8'h0A;
                                ESC_R:     esc_value = 8'h0D;
                                ESC_T:     esc_value = 8'h09;
                                ESC_B:     esc_value = 8'h08;
                                ESC_F:     esc_value = 8'h0C;
                                default: begin
                                    esc_ok    = 1'b0;
                                    esc_value = 8'h00;
                                end
                            endcase
                            if (esc_ok) begin
                                res       = {res, make_result(esc_value, ST_BYTE)};
                                scan_mode = MODE_STR;
                            end else begin
                                res       = {res, make_result(8'h00, ST_ERROR)};
                                scan_mode = MODE_IDLE;
                            end
                        end
                    end
                    MODE_HEX: begin
                        nib_ok = 1'b1;
                        nib    = 4'h0;
                        if (c >= "0" && c <= "9")
                            nib = 4'(c - 8'h30);
                        else if (c >= "a" && c <= "f")
                            nib = 4'(c - 8'h57);
                        else if (c >= "A" && c <= "F")
                            nib = 4'(c - 8'h37);
                        else
                            nib_ok = 1'b0;
                        if (!nib_ok) begin
                            res       = {res, make_result(8'h00, ST_ERROR)};
                            scan_mode = MODE_IDLE;
                        end else begin
                            code_accum = {code_accum[11:0], nib};
                            if (hex_digits == 2'd3) begin
                                // Fourth digit: emit the code point as UTF-8
                                cp = code_accum;
                                if (cp < CP_ONE_LIMIT) begin
                                    res = {res, make_result(cp[7:0], ST_BYTE)};
                                end else if (cp < CP_TWO_LIMIT) begin
                                    res = {res, make_result(LEAD_TWO | {3'b000, cp[10:6]},
                                                            ST_BYTE)};
                                    res = {res, make_result(CONT_BYTE | {2'b00, cp[5:0]},
                                                            ST_BYTE)};
                                end else begin
                                    res = {res, make_result(LEAD_THREE | {4'h0, cp[15:12]},
                                                            ST_BYTE)};
                                    res = {res, make_result(CONT_BYTE | {2'b00, cp[11:6]},
                                                            ST_BYTE)};
                                    res = {res, make_result(CONT_BYTE | {2'b00, cp[5:0]},
                                                            ST_BYTE)};
                                end
                                hex_digits = 2'd0;
                                code_accum = 16'd0;
                                scan_mode  = MODE_STR;
                            end else begin
                                hex_digits = hex_digits + 2'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        for (int i = 0; i < res.size(); i++) begin
            res[i].last     = (i == res.size() - 1);
            decoded_results = {decoded_results, res[i]};
        end
    endtask

    // Predict on accepted input items, compare on accepted results
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            scan_mode  = MODE_IDLE;
            hex_digits = 2'd0;
            code_accum = 16'd0;
            decoded_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decode_item(i_in_item);
            if (i_out_valid && i_out_ready) begin
                if (decoded_results.size() == 0) begin
                    $error("unexpected result: out_byte %h status %0d last %0b",
                           i_out_item.out_byte, i_out_item.status, i_out_item.last);
                    mismatch_cnt++;
                end else begin
                    want = decoded_results.pop_front();
                    checked_cnt++;
                    if (i_out_item.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, i_out_item.out_byte);
                        mismatch_cnt++;
                    end
                    if (i_out_item.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_item.status);
                        mismatch_cnt++;
                    end
                    if (i_out_item.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_out_item.last);
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_fail_cnt    <= mismatch_cnt;
        o_pending_cnt <= decoded_results.size();
        o_checked_cnt <= checked_cnt;
    end

endmodule

>>> verif/tb_top.sv
// Testbench top: drives string items into the decoder and gives the verdict.
`timescale 1ns / 1ps

module tb_top;
    import jsud_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 120;
    localparam int HOLD_CYCLES  = 120;
    localparam logic [7:0] ESC_LETTERS [8] = '{CH_QUOTE, CH_BSLASH, "/", "n", "r", "t", "b", "f"};

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_cnt;
    int pending_cnt;
    int checked_cnt;
    int cycle_cnt       = 0;
    int items_sent      = 0;
    int counted_items   = 0;
    int strings_opened  = 0;
    int unicode_escapes = 0;

    // Shared pacing controls: idle_off removes gaps on both sides
    bit idle_off = 1'b0;
    bit hold_req = 1'b0;

    json_string_unescape_decoder_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    jsud_scoreboard u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_fail_cnt   (fail_cnt),
        .o_pending_cnt(pending_cnt),
        .o_checked_cnt(checked_cnt)
    );

    always #6 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result sink: random stalls, one long hold-off when asked
    initial begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                stall     = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                stall = idle_off ? 0 : $urandom_range(0, 7);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // Offer one item after a random gap and wait until it is taken
    task automatic send_item(input logic [1:0] kind, input logic [7:0] value, input bit counted);
        int gap;
        gap = idle_off ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{kind: kind, data_byte: value};
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (counted)
            counted_items++;
        if (kind == KIND_START)
            strings_opened++;
    endtask

    task automatic send_byte(input logic [7:0] value);
        send_item(KIND_DATA, value, 1'b1);
    endtask

    // Control kinds carry a random data byte, which must be ignored
    task automatic send_ctrl(input logic [1:0] kind);
        send_item(kind, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
        if (nib < 4'd10)
            return 8'h30 + nib;
        return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
    endfunction

    task automatic send_hex_digits(input int count);
        for (int i = 0; i < count; i++)
            send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    endtask

    // \uXXXX with a code point from the 1, 2 or 3 byte UTF-8 range
    task automatic send_unicode(input int utf_len);
        logic [15:0] cp;
        bit          boundary;
        boundary = ($urandom_range(0, 5) == 0);
        case (utf_len)
            0:       cp = boundary ? 16'h007F : 16'($urandom_range(16'h0000, 16'h007F));
            1:       cp = boundary ? 16'h0080 : 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = boundary ? 16'hFFFF : 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        for (int i = 3; i >= 0; i--)
            send_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(0, 1))));
        unicode_escapes++;
    endtask

    // One string: mostly well formed, sometimes broken or cut short
    task automatic send_random_string();
        int         segs;
        int         sel;
        int         ending;
        bit         ok;
        logic [7:0] b;
        idle_off = ($urandom_range(0, 3) == 0);
        send_ctrl(KIND_START);
        segs = $urandom_range(1, 6);
        for (int i = 0; i < segs; i++) begin
            sel = $urandom_range(0, 11);
            if (sel <= 4) begin
                do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
                send_byte(b);
            end else if (sel <= 6) begin
                send_byte(CH_BSLASH);
                send_byte(ESC_LETTERS[$urandom_range(0, 7)]);
            end else if (sel <= 10) begin
                send_unicode($urandom_range(0, 2));
            end else begin
                send_ctrl(KIND_NOP);
            end
        end
        ending = $urandom_range(0, 11);
        if (ending == 7) begin
            send_ctrl(KIND_END);
        end else if (ending == 8) begin
            // escape letter outside the known set
            do begin
                b  = 8'($urandom_range(0, 255));
                ok = (b != CH_U);
                for (int k = 0; k < 8; k++)
                    if (b == ESC_LETTERS[k])
                        ok = 1'b0;
            end while (!ok);
            send_byte(CH_BSLASH);
            send_byte(b);
        end else if (ending == 9) begin
            // non-hex character among the four digits
            send_byte(CH_BSLASH);
            send_byte(CH_U);
            send_hex_digits($urandom_range(0, 3));
            do b = 8'($urandom_range(0, 255));
            while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
            send_byte(b);
        end else if (ending == 10) begin
            // input ends after a backslash or inside the digits
            send_byte(CH_BSLASH);
            if ($urandom_range(0, 1)) begin
                send_byte(CH_U);
                send_hex_digits($urandom_range(0, 3));
            end
            send_ctrl(KIND_END);
        end else if (ending != 11) begin
            send_byte(CH_QUOTE);
        end
        // trailing bytes after the string closed are ignored by the block
        if (ending != 11 && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3))
                send_item(KIND_DATA, 8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 1))
                send_item(KIND_END, 8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: idle handling, byte extremes, escapes, errors
        send_byte("x");
        send_ctrl(KIND_END);
        send_ctrl(KIND_START);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_ctrl(KIND_NOP);
        send_byte(CH_BSLASH);
        send_byte("n");
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte("F");
        send_byte("f");
        send_byte("F");
        send_byte("f");
        send_byte(CH_QUOTE);
        send_ctrl(KIND_START);
        send_byte(CH_BSLASH);
        send_byte(CH_U);
        send_byte("0");
        send_byte("g");
        send_ctrl(KIND_START);
        send_ctrl(KIND_START);
        send_byte(CH_BSLASH);
        send_byte("q");
        send_ctrl(KIND_START);
        send_ctrl(KIND_END);

        // Back-pressure: sink holds off while three-byte escapes keep coming
        idle_off = 1'b1;
        hold_req = 1'b1;
        send_ctrl(KIND_START);
        repeat (5) send_unicode(2);
        send_byte(CH_QUOTE);

        while (counted_items < RANDOM_ITEMS)
            send_random_string();
        in_valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending_cnt != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (pending_cnt != 0)
            $error("%0d decoded results never arrived", pending_cnt);

        $display("Sent %0d items over %0d strings, %0d of them unicode escapes.",
                 items_sent, strings_opened, unicode_escapes);
        $display("Checked %0d results with %0d mismatches.", checked_cnt, fail_cnt);
        if (fail_cnt == 0 && pending_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
